// ===== rtl/core/hts_pkg.sv =====
`timescale 1ns / 1ps
package hts_pkg;

	localparam int GRID_CELLS_DEF = 512;
	localparam int SAMPLE_W = 8;
	localparam int FRAC_W = 16;
	localparam int INTERP_W = 24;
	localparam int HEIGHT_W = 32;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam logic [1:0] REG_GRID_PER_WORLD = 2'd0;
	localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;

	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 32'd4278124800;

	typedef struct packed {
		logic [FRAC_W-1:0] fu;
		logic [FRAC_W-1:0] fv;
	} frac_pair_t;

endpackage

// ===== rtl/core/hts_bank.sv =====
`timescale 1ns / 1ps
module hts_bank #(
	parameter int DEPTH = 66049,
	parameter int AW = 17
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [hts_pkg::SAMPLE_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [hts_pkg::SAMPLE_W-1:0] rdata
);

	logic [hts_pkg::SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/hts_map.sv =====
`timescale 1ns / 1ps
module hts_map import hts_pkg::*; #(
	parameter int GRID_CELLS = GRID_CELLS_DEF,
	parameter int IW = 10
) (
	input  logic                     clk,
	input  logic                     en1,
	input  logic                     en2,
	input  logic signed [32:0]       pos,
	input  logic [31:0]              gpw,
	output logic                     inr_s2,
	output logic [IW-1:0]            cell_s2,
	output logic [FRAC_W-1:0]        frac_s2
);

	localparam logic signed [65:0] HALF_C = 66'(GRID_CELLS / 2) <<< 32;
	localparam logic [32:0] TOP_CELL = 33'(GRID_CELLS - 1);

	logic signed [64:0] prod_s1;
	logic signed [65:0] coord;
	logic               inr;

	// The product keeps the full 32-bit fraction, so the range test is exact.
	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= 65'($signed(pos) * $signed({1'b0, gpw}));
		end
	end

	assign coord = 66'(prod_s1) + HALF_C;
	assign inr = !coord[65] && (coord[64:32] < TOP_CELL);

	always_ff @(posedge clk) begin
		if (en2) begin
			inr_s2 <= inr;
			cell_s2 <= coord[32+IW-1:32];
			frac_s2 <= coord[31:16];
		end
	end

endmodule

// ===== rtl/core/hts_interp.sv =====
`timescale 1ns / 1ps
module hts_interp import hts_pkg::*; (
	input  logic                  clk,
	input  logic                  en4,
	input  logic                  en5,
	input  logic                  inr_s3,
	input  logic [SAMPLE_W-1:0]   h00,
	input  logic [SAMPLE_W-1:0]   h10,
	input  logic [SAMPLE_W-1:0]   h01,
	input  logic [SAMPLE_W-1:0]   h11,
	input  frac_pair_t            fr_s3,
	input  logic [15:0]           scale,
	output logic                  inr_s5,
	output logic [HEIGHT_W-1:0]   height_s5
);

	logic signed [16:0] fu, fv;
	logic signed [8:0]  d1, d2;
	logic signed [25:0] p1, p2;
	logic signed [26:0] sum;
	logic [INTERP_W-1:0] interp_s4;
	logic                inr_s4;
	logic [39:0]         scaled;

	assign fu = $signed({1'b0, fr_s3.fu});
	assign fv = $signed({1'b0, fr_s3.fv});

	// The upper triangle is taken when the u fraction is the larger one.
	always_comb begin
		if (fr_s3.fu > fr_s3.fv) begin
			d1 = $signed({1'b0, h10}) - $signed({1'b0, h00});
			d2 = $signed({1'b0, h11}) - $signed({1'b0, h10});
		end else begin
			d1 = $signed({1'b0, h11}) - $signed({1'b0, h01});
			d2 = $signed({1'b0, h01}) - $signed({1'b0, h00});
		end
	end

	assign p1 = fu * d1;
	assign p2 = fv * d2;
	assign sum = $signed({3'b000, h00, 16'h0000}) + 27'(p1) + 27'(p2);

	always_ff @(posedge clk) begin
		if (en4) begin
			inr_s4 <= inr_s3;
			interp_s4 <= sum[26] ? '0 : sum[INTERP_W-1:0];
		end
	end

	assign scaled = 40'(interp_s4) * 40'(scale);

	always_ff @(posedge clk) begin
		if (en5) begin
			inr_s5 <= inr_s4;
			height_s5 <= inr_s4 ? scaled[39:8] : '0;
		end
	end

endmodule

// ===== rtl/core/heightmap_triangle_sampler.sv =====
`timescale 1ns / 1ps
// Height sampler over a square grid of 8-bit samples. Items enter at one per
// cycle while req_stall is low; each sample item gives its result from the last
// stage; load items give no result. The store is split into four banks by row
// and column parity, so the four corners of a cell are read in the same cycle,
// and a load is written at the same pipeline stage where samples read, so a
// sample always sees every load accepted before it. Samples never loaded read as
// undefined. Registers are to be written only while no item is in flight.
module heightmap_triangle_sampler import hts_pkg::*; #(
	parameter int GRID_CELLS = GRID_CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 mode,
	input  logic [31:0]          pos_x,
	input  logic [31:0]          pos_z,
	input  logic [9:0]           load_col,
	input  logic [9:0]           load_row,
	input  logic [SAMPLE_W-1:0]  load_value,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 in_range,
	output logic [HEIGHT_W-1:0]  height
);

	localparam int IW = $clog2(GRID_CELLS + 1);
	localparam int HALF = (GRID_CELLS + 2) / 2;
	localparam int HW = $clog2(HALF);
	localparam int BANK_DEPTH = HALF * HALF;
	localparam int AW = $clog2(BANK_DEPTH);

	logic [31:0] gpw_q;
	logic [15:0] scale_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic free1, free2, free3, free4, free5;

	logic                mode_s1, mode_s2;
	logic [9:0]          col_s1, col_s2, row_s1, row_s2;
	logic [SAMPLE_W-1:0] val_s1, val_s2;

	logic          inr_u, inr_v;
	logic [IW-1:0] cu, cv;
	frac_pair_t    fr2;
	frac_pair_t    fr_s3;
	logic          inr_s3, pu_s3, pv_s3;

	logic [31:0]   lc, lr;
	logic          load_ok;
	logic [AW-1:0] waddr;
	logic [1:0]    wbank;
	logic [SAMPLE_W-1:0] rd [4];
	logic [HW-1:0] ch [2];
	logic [HW-1:0] rh [2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpw_q <= 32'h0100_0000;
			scale_q <= 16'h0100;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GRID_PER_WORLD: gpw_q <= cfg_data;
				REG_HEIGHT_SCALE:   scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A stage takes a new item when it is empty or its item moves on.
	assign free5 = !v5_s5 || !rsp_stall;
	assign free4 = !v4_s4 || free5;
	assign free3 = !v3_s3 || free4;
	assign free2 = !v2_s2 || free3;
	assign free1 = !v1_s1 || free2;
	assign req_stall = !free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (free1) v1_s1 <= req_valid;
			if (free2) v2_s2 <= v1_s1;
			if (free3) v3_s3 <= v2_s2 && (mode_s2 == MODE_SAMPLE);
			if (free4) v4_s4 <= v3_s3;
			if (free5) v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free1) begin
			mode_s1 <= mode;
			col_s1 <= load_col;
			row_s1 <= load_row;
			val_s1 <= load_value;
		end
		if (free2) begin
			mode_s2 <= mode_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			val_s2 <= val_s1;
		end
	end

	hts_map #(.GRID_CELLS(GRID_CELLS), .IW(IW)) u_map_u (
		.clk     (clk),
		.en1     (free1),
		.en2     (free2),
		.pos     ($signed({pos_x[31], pos_x})),
		.gpw     (gpw_q),
		.inr_s2  (inr_u),
		.cell_s2 (cu),
		.frac_s2 (fr2.fu)
	);

	// Grid v runs against world Z.
	hts_map #(.GRID_CELLS(GRID_CELLS), .IW(IW)) u_map_v (
		.clk     (clk),
		.en1     (free1),
		.en2     (free2),
		.pos     (-$signed({pos_z[31], pos_z})),
		.gpw     (gpw_q),
		.inr_s2  (inr_v),
		.cell_s2 (cv),
		.frac_s2 (fr2.fv)
	);

	assign lc = 32'(col_s2);
	assign lr = 32'(row_s2);
	assign load_ok = (lc <= 32'(GRID_CELLS)) && (lr <= 32'(GRID_CELLS));
	assign wbank = {lr[0], lc[0]};
	assign waddr = AW'(AW'(HW'(lr[IW-1:0] >> 1)) * AW'(HALF) + AW'(HW'(lc[IW-1:0] >> 1)));

	// Half-index of the corner row or column that falls in a bank of each parity.
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			rh[p] = HW'(cv >> 1) + HW'(cv[0] & (p == 0));
			ch[p] = HW'(cu >> 1) + HW'(cu[0] & (p == 0));
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		hts_bank #(.DEPTH(BANK_DEPTH), .AW(AW)) u_bank (
			.clk   (clk),
			.we    (free3 && v2_s2 && (mode_s2 == MODE_LOAD) && load_ok && (wbank == 2'(b))),
			.waddr (waddr),
			.wdata (val_s2),
			.re    (free3),
			.raddr (AW'(AW'(rh[b/2]) * AW'(HALF) + AW'(ch[b%2]))),
			.rdata (rd[b])
		);
	end

	always_ff @(posedge clk) begin
		if (free3) begin
			inr_s3 <= inr_u && inr_v;
			pu_s3 <= cu[0];
			pv_s3 <= cv[0];
			fr_s3 <= fr2;
		end
	end

	hts_interp u_interp (
		.clk       (clk),
		.en4       (free4),
		.en5       (free5),
		.inr_s3    (inr_s3),
		.h00       (rd[{pv_s3, pu_s3}]),
		.h10       (rd[{pv_s3, !pu_s3}]),
		.h01       (rd[{!pv_s3, pu_s3}]),
		.h11       (rd[{!pv_s3, !pu_s3}]),
		.fr_s3     (fr_s3),
		.scale     (scale_q),
		.inr_s5    (in_range),
		.height_s5 (height)
	);

	assign rsp_valid = v5_s5;

endmodule

// ===== rtl/core/hts_checker.sv =====
`timescale 1ns / 1ps
module hts_checker import hts_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic                in_range,
	input logic [HEIGHT_W-1:0] height
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(height) && $stable(in_range))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !in_range |-> height == '0)
		else $error("out-of-range result has non-zero height");

	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> height <= HEIGHT_MAX)
		else $error("height above largest possible value");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result shown straight after reset");

endmodule

bind heightmap_triangle_sampler hts_checker u_hts_checker (.*);
